/* hw/rtl/mmtc_pkg.sv */
// Shared types and constants for the modular two-column matrix product unit.
// No dependencies; every other file of the block but mmtc_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mmtc_pkg;

  // Fixed field widths
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned COEFF_W = 32;
  localparam int unsigned MOD_W   = 32;
  localparam int unsigned ACC_W   = 64;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_MAX_COLS   = 4096;
  localparam int unsigned DEF_COEFF_BITS = 32;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_ELEM = 1'b1;

  // One element beat after its column values have been fetched
  typedef struct packed {
    logic [COEFF_W-1:0] elem;
    logic [COEFF_W-1:0] b_first;
    logic [COEFF_W-1:0] b_second;
    logic               row_last;
    logic               matrix_end;
  } entry_t;

endpackage

`default_nettype wire

/* hw/rtl/mmtc_stream_if.sv */
// Valid/ready channel interfaces for item beats and result beats.
// Depends on mmtc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mmtc_item_if;
  import mmtc_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [IDX_W-1:0]   col_index;
  logic [COEFF_W-1:0] elem_value;
  logic [COEFF_W-1:0] first_col_value;
  logic [COEFF_W-1:0] second_col_value;
  logic               row_end;
  logic               matrix_end;

  modport source (
    output valid, kind, col_index, elem_value, first_col_value, second_col_value,
           row_end, matrix_end,
    input  ready
  );
  modport sink (
    input  valid, kind, col_index, elem_value, first_col_value, second_col_value,
           row_end, matrix_end,
    output ready
  );
endinterface

interface mmtc_result_if;
  import mmtc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACC_W-1:0] residue_first;
  logic [ACC_W-1:0] residue_second;
  logic             matrix_done;

  modport source (
    output valid, residue_first, residue_second, matrix_done,
    input  ready
  );
  modport sink (
    input  valid, residue_first, residue_second, matrix_done,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/mmtc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mmtc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mmtc_front.sv */
// Front end: accepts item beats, writes column pairs, fetches column values
// for element beats and pushes them to the queue. Uses mmtc_pkg, mmtc_ram.
`timescale 1ns / 1ps
`default_nettype none

module mmtc_front #(
  parameter int unsigned MAX_COLS   = mmtc_pkg::DEF_MAX_COLS,
  parameter int unsigned COEFF_BITS = mmtc_pkg::DEF_COEFF_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  mmtc_item_if.sink                      item,
  input  wire logic [mmtc_pkg::QCNT_W-1:0] q_count,
  output logic                           push,
  output mmtc_pkg::entry_t               push_data
);
  import mmtc_pkg::*;

  localparam int unsigned ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned EXT_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

  logic                  accept;
  logic                  in_range;
  logic [EXT_W-1:0]      idx_ext;
  logic [ADDR_W-1:0]     addr;
  logic                  load_we;
  logic                  elem_re;
  logic [COEFF_BITS-1:0] rd_first;
  logic [COEFF_BITS-1:0] rd_second;
  logic [QCNT_W:0]       occupied;

  // Element held while its registered column read data arrives
  logic               pend_v;
  logic [COEFF_W-1:0] pend_elem;
  logic               pend_zero;
  logic               pend_row_last;
  logic               pend_mend;

  // Room check counts the beat still in flight from the RAM
  assign occupied   = {1'b0, q_count} + {{QCNT_W{1'b0}}, pend_v};
  assign item.ready = occupied < (QCNT_W + 1)'(QUEUE_DEPTH);
  assign accept     = item.valid && item.ready;

  assign idx_ext  = EXT_W'(item.col_index);
  assign addr     = idx_ext[ADDR_W-1:0];
  assign in_range = {1'b0, idx_ext} < (EXT_W + 1)'(MAX_COLS);

  assign load_we = accept && (item.kind == KIND_LOAD) && in_range;
  assign elem_re = accept && (item.kind == KIND_ELEM);

  mmtc_ram #(
    .WIDTH (COEFF_BITS),
    .DEPTH (MAX_COLS)
  ) u_first_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (addr),
    .wdata (item.first_col_value[COEFF_BITS-1:0]),
    .re    (elem_re),
    .raddr (addr),
    .rdata (rd_first)
  );

  mmtc_ram #(
    .WIDTH (COEFF_BITS),
    .DEPTH (MAX_COLS)
  ) u_second_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (addr),
    .wdata (item.second_col_value[COEFF_BITS-1:0]),
    .re    (elem_re),
    .raddr (addr),
    .rdata (rd_second)
  );

  // Hold element fields while the column read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else begin
      pend_v <= elem_re;
    end
    if (elem_re) begin
      pend_elem     <= COEFF_W'(item.elem_value[COEFF_BITS-1:0]);
      pend_zero     <= !in_range;
      pend_row_last <= item.row_end || item.matrix_end;
      pend_mend     <= item.matrix_end;
    end
  end

  // Out-of-range columns contribute zero
  assign push                 = pend_v;
  assign push_data.elem       = pend_elem;
  assign push_data.b_first    = pend_zero ? '0 : COEFF_W'(rd_first);
  assign push_data.b_second   = pend_zero ? '0 : COEFF_W'(rd_second);
  assign push_data.row_last   = pend_row_last;
  assign push_data.matrix_end = pend_mend;

endmodule

`default_nettype wire

/* hw/rtl/mmtc_queue.sv */
// Short FIFO of fetched element beats between front and back.
// Uses mmtc_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module mmtc_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire mmtc_pkg::entry_t            push_data,
  input  wire logic                        pop,
  output mmtc_pkg::entry_t                 head,
  output logic                             head_valid,
  output logic [mmtc_pkg::QCNT_W-1:0]      count
);
  import mmtc_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic              do_pop;

  assign head_valid = count != '0;
  assign head       = slots[rptr];
  assign do_pop     = pop && head_valid;

  // Front guarantees room before it pushes
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mmtc_back.sv */
// Back end: multiplies each element by its two column values, accumulates,
// reduces mod q with a bit-serial remainder unit when q is nonzero, and emits row results.
// Uses mmtc_pkg and mmtc_result_if.
`timescale 1ns / 1ps
`default_nettype none

module mmtc_back #(
  parameter int unsigned COEFF_BITS = mmtc_pkg::DEF_COEFF_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [mmtc_pkg::MOD_W-1:0] modulus,
  input  wire mmtc_pkg::entry_t           head,
  input  wire logic                       head_valid,
  output logic                            pop,
  mmtc_result_if.source                   result
);
  import mmtc_pkg::*;

  localparam int unsigned PROD_W = 2 * COEFF_BITS;
  localparam int unsigned SUM_W  = ACC_W + 1;
  localparam int unsigned CNT_W  = $clog2(SUM_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_DIV,
    S_EMIT
  } state_t;

  state_t state;

  logic [COEFF_BITS-1:0] op_elem;
  logic [COEFF_BITS-1:0] op_b0;
  logic [COEFF_BITS-1:0] op_b1;
  logic                  op_last;
  logic                  op_done;
  logic [PROD_W-1:0]     prod0;
  logic [PROD_W-1:0]     prod1;
  logic [PROD_W-1:0]     prod0_next;
  logic [PROD_W-1:0]     prod1_next;
  logic [ACC_W-1:0]      acc0;
  logic [ACC_W-1:0]      acc1;
  logic [SUM_W-1:0]      sum0;
  logic [SUM_W-1:0]      sum1;
  logic [SUM_W-1:0]      dvd0;
  logic [SUM_W-1:0]      dvd1;
  logic [MOD_W-1:0]      rem0;
  logic [MOD_W-1:0]      rem1;
  logic [MOD_W-1:0]      rem0_next;
  logic [MOD_W-1:0]      rem1_next;
  logic [MOD_W:0]        trial0;
  logic [MOD_W:0]        trial1;
  logic [CNT_W-1:0]      bit_cnt;
  logic                  out_free;

  assign pop = (state == S_IDLE) && head_valid;

  // One COEFF_BITS x COEFF_BITS product per column, registered
  assign prod0_next = op_elem * op_b0;
  assign prod1_next = op_elem * op_b1;

  // Wide unreduced sum; one extra bit keeps the carry
  assign sum0 = {1'b0, acc0} + {1'b0, ACC_W'(prod0)};
  assign sum1 = {1'b0, acc1} + {1'b0, ACC_W'(prod1)};

  // Restoring remainder step: shift in one dividend bit, subtract q if it fits
  assign trial0    = {rem0, dvd0[SUM_W-1]};
  assign trial1    = {rem1, dvd1[SUM_W-1]};
  assign rem0_next = (trial0 >= {1'b0, modulus}) ? MOD_W'(trial0 - {1'b0, modulus})
                                                 : trial0[MOD_W-1:0];
  assign rem1_next = (trial1 >= {1'b0, modulus}) ? MOD_W'(trial1 - {1'b0, modulus})
                                                 : trial1[MOD_W-1:0];

  assign out_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
      acc0         <= '0;
      acc1         <= '0;
    end else begin
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (head_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_SUM;
        end
        S_SUM: begin
          if (modulus == '0) begin
            acc0  <= sum0[ACC_W-1:0];
            acc1  <= sum1[ACC_W-1:0];
            state <= op_last ? S_EMIT : S_IDLE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (bit_cnt == CNT_W'(SUM_W - 1)) begin
            acc0  <= ACC_W'(rem0_next);
            acc1  <= ACC_W'(rem1_next);
            state <= op_last ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            result.valid <= 1'b1;
            acc0         <= '0;
            acc1         <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end

    // Datapath registers
    if (pop) begin
      op_elem <= head.elem[COEFF_BITS-1:0];
      op_b0   <= head.b_first[COEFF_BITS-1:0];
      op_b1   <= head.b_second[COEFF_BITS-1:0];
      op_last <= head.row_last;
      op_done <= head.matrix_end;
    end
    if (state == S_MUL) begin
      prod0 <= prod0_next;
      prod1 <= prod1_next;
    end
    if (state == S_SUM) begin
      dvd0    <= sum0;
      dvd1    <= sum1;
      rem0    <= '0;
      rem1    <= '0;
      bit_cnt <= '0;
    end
    if (state == S_DIV) begin
      dvd0    <= dvd0 << 1;
      dvd1    <= dvd1 << 1;
      rem0    <= rem0_next;
      rem1    <= rem1_next;
      bit_cnt <= bit_cnt + 1'b1;
    end
    if (state == S_EMIT && out_free) begin
      result.residue_first  <= acc0;
      result.residue_second <= acc1;
      result.matrix_done    <= op_done;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/modular_matrix_two_column_product_unit.sv */
// Top level: modulus register, front end, beat queue and back end.
// The back end takes each element through a multiply state, a sum state and, with q != 0,
// a 65-step bit-serial remainder (one bit a cycle), plus an emit state on a row's last
// element. Synchronous reset clears the modulus, accumulators, queue and handshakes; the
// column RAMs are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module modular_matrix_two_column_product_unit #(
  parameter int unsigned MAX_COLS   = mmtc_pkg::DEF_MAX_COLS,
  parameter int unsigned COEFF_BITS = mmtc_pkg::DEF_COEFF_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [mmtc_pkg::MOD_W-1:0] cfg_wr_data,
  mmtc_item_if.sink                       item,
  mmtc_result_if.source                   result
);
  import mmtc_pkg::*;

  logic [MOD_W-1:0]  modulus;
  logic              push;
  entry_t            push_data;
  logic              pop;
  entry_t            head;
  logic              head_valid;
  logic [QCNT_W-1:0] q_count;

  // Modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= '0;
    end else if (cfg_wr_en) begin
      modulus <= cfg_wr_data;
    end
  end

  mmtc_front #(
    .MAX_COLS   (MAX_COLS),
    .COEFF_BITS (COEFF_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  mmtc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .count      (q_count)
  );

  mmtc_back #(
    .COEFF_BITS (COEFF_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .modulus    (modulus),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .result     (result)
  );

endmodule

`default_nettype wire

/* verif/tb_modular_matrix_two_column_product_unit.sv */
// Self-checking testbench for modular_matrix_two_column_product_unit.
// Depends on mmtc_pkg and the mmtc_item_if / mmtc_result_if channel interfaces.
// A scoreboard class predicts the row residues per accepted beat and checks each result beat.
`timescale 1ns / 1ps

module tb_modular_matrix_two_column_product_unit;
  import mmtc_pkg::*;

  localparam int unsigned NUM_COLS      = DEF_MAX_COLS;
  localparam int          ITEM_TARGET   = 1050;
  localparam int          NUM_PHASES    = 10;
  // Up to 4 queued elements plus one in the back end
  localparam int          SETTLE_CYCLES = 400;
  localparam int          HOLD_CYCLES   = 300;

  typedef struct packed {
    logic               kind;
    logic [IDX_W-1:0]   col_index;
    logic [COEFF_W-1:0] elem_value;
    logic [COEFF_W-1:0] first_col_value;
    logic [COEFF_W-1:0] second_col_value;
    logic               row_end;
    logic               matrix_end;
  } item_beat_t;

  typedef struct packed {
    logic [ACC_W-1:0] residue_first;
    logic [ACC_W-1:0] residue_second;
    logic             matrix_done;
  } row_sums_t;

  // Predicts row residues from accepted beats and checks result beats in order
  class row_sum_scoreboard;
    bit [COEFF_W-1:0] first_store [NUM_COLS];
    bit [COEFF_W-1:0] second_store[NUM_COLS];
    bit [ACC_W-1:0]   acc_first;
    bit [ACC_W-1:0]   acc_second;
    bit [MOD_W-1:0]   modulus;
    row_sums_t        expected_rows[$];
    int               mismatch_count;

    function new();
      acc_first      = '0;
      acc_second     = '0;
      modulus        = '0;
      mismatch_count = 0;
    endfunction

    // One accumulation step; with q != 0 both remainders stay below 2^32, so no overflow
    function bit [ACC_W-1:0] fold_residue(bit [ACC_W-1:0] acc, bit [ACC_W-1:0] prod);
      bit [ACC_W-1:0] q;
      q = {32'b0, modulus};
      if (q == 0) return acc + prod;
      return ((acc % q) + (prod % q)) % q;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatch_count++;
    endtask

    function void note_beat(item_beat_t b);
      bit [ACC_W-1:0] q;
      row_sums_t      row;
      if (b.kind == KIND_LOAD) begin
        // Row marks on a load are ignored
        first_store[b.col_index]  = b.first_col_value;
        second_store[b.col_index] = b.second_col_value;
        return;
      end
      acc_first  = fold_residue(acc_first,
                                {32'b0, b.elem_value} * {32'b0, first_store[b.col_index]});
      acc_second = fold_residue(acc_second,
                                {32'b0, b.elem_value} * {32'b0, second_store[b.col_index]});
      // Matrix end also closes the row
      if (!b.row_end && !b.matrix_end) return;
      q                  = {32'b0, modulus};
      row.residue_first  = (q != 0) ? acc_first % q : acc_first;
      row.residue_second = (q != 0) ? acc_second % q : acc_second;
      row.matrix_done    = b.matrix_end;
      expected_rows.push_back(row);
      acc_first  = '0;
      acc_second = '0;
    endfunction

    task check_row(row_sums_t got);
      row_sums_t want;
      if (expected_rows.size() == 0) begin
        report($sformatf("result beat with no row pending: %h %h done=%b",
                         got.residue_first, got.residue_second, got.matrix_done));
        return;
      end
      want = expected_rows.pop_front();
      if (got.residue_first !== want.residue_first)
        report($sformatf("residue_first got %h want %h", got.residue_first, want.residue_first));
      if (got.residue_second !== want.residue_second)
        report($sformatf("residue_second got %h want %h",
                         got.residue_second, want.residue_second));
      if (got.matrix_done !== want.matrix_done)
        report($sformatf("matrix_done got %b want %b", got.matrix_done, want.matrix_done));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  logic [MOD_W-1:0] cfg_wr_data;

  mmtc_item_if   item_bus();
  mmtc_result_if result_bus();

  modular_matrix_two_column_product_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item_bus),
    .result      (result_bus)
  );

  row_sum_scoreboard board;

  // Stimulus bookkeeping: only written columns are ever read
  bit        col_written[NUM_COLS];
  int        written_cols[$];
  int        items_sent;
  int        burst_left;
  int        hold_requests;
  int        holds_done;
  // Receiver pattern state
  int        rx_cycle;
  int        rx_mode;
  int        hold_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("tb_modular_matrix_two_column_product_unit failed");
    $finish;
  end

  // Receiver: checks accepted result beats, stalls on its own pattern
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready)
        board.check_row({result_bus.residue_first, result_bus.residue_second,
                         result_bus.matrix_done});
      if (hold_requests != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       result_bus.ready <= 1'b1;
          1:       result_bus.ready <= 1'($urandom_range(0, 1));
          2:       result_bus.ready <= ($urandom_range(0, 3) == 0);
          default: result_bus.ready <= (rx_cycle % 7 != 0);
        endcase
      end
      rx_cycle++;
      if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
    end
  end

  function automatic logic [COEFF_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return COEFF_W'($urandom_range(0, 15));
      default: return COEFF_W'($urandom);
    endcase
  endfunction

  function automatic item_beat_t make_load(int idx, logic [COEFF_W-1:0] v0,
                                           logic [COEFF_W-1:0] v1, logic re, logic me);
    item_beat_t b;
    b.kind             = KIND_LOAD;
    b.col_index        = IDX_W'(idx);
    b.elem_value       = COEFF_W'($urandom);
    b.first_col_value  = v0;
    b.second_col_value = v1;
    b.row_end          = re;
    b.matrix_end       = me;
    return b;
  endfunction

  function automatic item_beat_t make_elem(int idx, logic [COEFF_W-1:0] v, logic re, logic me);
    item_beat_t b;
    b.kind             = KIND_ELEM;
    b.col_index        = IDX_W'(idx);
    b.elem_value       = v;
    b.first_col_value  = COEFF_W'($urandom);
    b.second_col_value = COEFF_W'($urandom);
    b.row_end          = re;
    b.matrix_end       = me;
    return b;
  endfunction

  function automatic int pick_col();
    return written_cols[$urandom_range(0, written_cols.size() - 1)];
  endfunction

  // Offer one beat and hold it until accepted; valid stays high on return
  task automatic drive_beat(item_beat_t b);
    item_bus.valid            <= 1'b1;
    item_bus.kind             <= b.kind;
    item_bus.col_index        <= b.col_index;
    item_bus.elem_value       <= b.elem_value;
    item_bus.first_col_value  <= b.first_col_value;
    item_bus.second_col_value <= b.second_col_value;
    item_bus.row_end          <= b.row_end;
    item_bus.matrix_end       <= b.matrix_end;
    do @(posedge clk); while (!item_bus.ready);
    board.note_beat(b);
    items_sent++;
    if (b.kind == KIND_LOAD && !col_written[b.col_index]) begin
      col_written[b.col_index] = 1'b1;
      written_cols.push_back(int'(b.col_index));
    end
  endtask

  task automatic idle_cycles(int n);
    if (n == 0) return;
    item_bus.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Bursts of random length with random gaps between them
  task automatic paced_beat(item_beat_t b);
    int gap;
    drive_beat(b);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: gap = 0;
        5:             gap = 40;
        default:       gap = $urandom_range(1, 12);
      endcase
      burst_left = $urandom_range(0, 47);
      idle_cycles(gap);
    end
  endtask

  // Wait for every pending row, then let trailing elements finish
  task automatic wait_for_idle();
    item_bus.valid <= 1'b0;
    do @(posedge clk); while (board.expected_rows.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_modulus(logic [MOD_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.modulus = value;
  endtask

  // A row over written columns; matrix end sometimes closes it, also before its last element
  task automatic stream_row(int len);
    logic me;
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) begin
        me = ($urandom_range(0, 3) == 0);
        paced_beat(make_elem(pick_col(), rand_word(), ~me | 1'($urandom_range(0, 1)), me));
      end else begin
        me = ($urandom_range(0, 29) == 0);
        paced_beat(make_elem(pick_col(), rand_word(), 1'b0, me));
      end
    end
  endtask

  task automatic load_columns(int n, bit noisy);
    for (int i = 0; i < n; i++)
      paced_beat(make_load($urandom_range(0, NUM_COLS - 1), rand_word(), rand_word(),
                           noisy ? 1'($urandom_range(0, 1)) : 1'b0,
                           noisy ? 1'($urandom_range(0, 1)) : 1'b0));
  endtask

  // Directed: field extremes, wraparound, row marks on loads, modulus changes mid-row
  task automatic run_directed();
    drive_beat(make_load(0, '1, '1, 1'b1, 1'b1));
    drive_beat(make_load(NUM_COLS - 1, '0, 32'd1, 1'b0, 1'b0));
    drive_beat(make_load(12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0));
    drive_beat(make_load(12'h555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b1));
    // Raw sums wrap past 64 bits
    drive_beat(make_elem(0, '1, 1'b0, 1'b0));
    drive_beat(make_elem(0, '1, 1'b0, 1'b0));
    drive_beat(make_elem(0, '1, 1'b1, 1'b0));
    drive_beat(make_elem(NUM_COLS - 1, '0, 1'b1, 1'b0));
    // Matrix end without row end
    drive_beat(make_elem(12'hAAA, 32'h5555_5555, 1'b0, 1'b1));
    drive_beat(make_elem(12'h555, 32'hAAAA_AAAA, 1'b1, 1'b1));
    wait_for_idle();
    write_modulus(32'hFFFF_FFFF);
    drive_beat(make_elem(0, '1, 1'b0, 1'b0));
    drive_beat(make_elem(12'h555, '1, 1'b1, 1'b0));
    // Modulus changed mid-row: max, then one
    drive_beat(make_elem(12'hAAA, 32'd12345, 1'b0, 1'b0));
    wait_for_idle();
    write_modulus(32'd1);
    drive_beat(make_elem(0, 32'd7, 1'b1, 1'b0));
    // One, then reduction off
    drive_beat(make_elem(0, '1, 1'b0, 1'b0));
    wait_for_idle();
    write_modulus('0);
    drive_beat(make_elem(0, '1, 1'b1, 1'b0));
    // Wrapped raw sum, then reduction on
    drive_beat(make_elem(0, '1, 1'b0, 1'b0));
    drive_beat(make_elem(0, '1, 1'b0, 1'b0));
    wait_for_idle();
    write_modulus(32'hFFFF_FFFB);
    drive_beat(make_elem(NUM_COLS - 1, 32'd1, 1'b1, 1'b0));
  endtask

  initial begin
    logic [MOD_W-1:0] mod_list[NUM_PHASES];
    bit               pressure_done;
    int               budget;

    board          = new();
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    item_bus.valid = 1'b0;
    item_bus.kind  = KIND_LOAD;
    item_bus.col_index        = '0;
    item_bus.elem_value       = '0;
    item_bus.first_col_value  = '0;
    item_bus.second_col_value = '0;
    item_bus.row_end          = 1'b0;
    item_bus.matrix_end       = 1'b0;
    result_bus.ready = 1'b0;
    items_sent    = 0;
    burst_left    = 0;
    hold_requests = 0;
    holds_done    = 0;
    rx_cycle      = 0;
    rx_mode       = 0;
    hold_left     = 0;
    pressure_done = 1'b0;

    mod_list[0] = '0;
    mod_list[1] = 32'd1;
    mod_list[2] = 32'hFFFF_FFFF;
    mod_list[3] = 32'd2;
    mod_list[4] = 32'hFFFF_FFFB;
    mod_list[5] = 32'h8000_0000;
    mod_list[6] = MOD_W'($urandom_range(3, 1000));
    mod_list[7] = MOD_W'($urandom);
    mod_list[8] = '0;
    mod_list[9] = MOD_W'($urandom) | 32'h8000_0000;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    // Random phases, one modulus each, written while the block is idle
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_for_idle();
      write_modulus(mod_list[p]);
      if (mod_list[p] == 0 && !pressure_done) begin
        // Long receiver hold-off while the sender keeps offering single-element rows
        pressure_done = 1'b1;
        hold_requests++;
        repeat (20) drive_beat(make_elem(pick_col(), rand_word(), 1'b1, 1'b0));
      end
      budget = ITEM_TARGET * (p + 1) / NUM_PHASES;
      while (items_sent < budget) begin
        case ($urandom_range(0, 19))
          0, 1, 2: load_columns($urandom_range(1, 6), 1'b0);
          3:       load_columns(1, 1'b1);
          4:       paced_beat(make_elem(pick_col(), rand_word(),
                                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
          5:       paced_beat(make_elem(pick_col(), rand_word(), 1'b0, 1'b0));
          default: stream_row($urandom_range(1, 8));
        endcase
      end
    end

    wait_for_idle();
    if (board.expected_rows.size() != 0)
      board.report($sformatf("%0d rows never arrived", board.expected_rows.size()));
    if (board.mismatch_count == 0)
      $display("tb_modular_matrix_two_column_product_unit passed");
    else
      $display("tb_modular_matrix_two_column_product_unit failed");
    $finish;
  end

endmodule
